>>> design/wst_pkg.sv
// shared types, constants and helpers for the weekly schedule table
// no dependencies; imported by wst_cell, weekly_schedule_table_top and its testbench
`default_nettype none

package wst_pkg;

  // number of table entries, one cell each
  localparam int TASK_COUNT = 16;
  localparam int CELL_ID_W  = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam int IDX_W      = 4;
  localparam int IDX_CMP_W  = (CELL_ID_W > IDX_W) ? CELL_ID_W : IDX_W;

  // field widths
  localparam int CODE_W   = 32;
  localparam int LEN_W    = 17;
  localparam int SEC_W    = 17;
  localparam int DAY_W    = 3;
  localparam int ACT_W    = 8;
  localparam int NEXT_W   = 20;
  localparam int CAND_W   = 21;

  // time constants
  localparam logic [SEC_W:0]    DAY_SECONDS = 18'd86400;
  localparam logic [NEXT_W-1:0] NONE_FOUND  = 20'd900000;

  // operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_CHECK = 2'd1;
  localparam logic [1:0] OP_NEXT  = 2'd2;

  // request plus running results, handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic [1:0]        op;
    logic [IDX_W-1:0]  idx;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic [SEC_W-1:0]  now;
    logic [DAY_W-1:0]  today;
    logic [ACT_W-1:0]  action;
    logic              hit0;
    logic [NEXT_W-1:0] min0;
    logic              hit1;
    logic [NEXT_W-1:0] min1;
  } chain_t;

  // seconds after midnight of a start code (fields unchecked)
  function automatic logic [SEC_W-1:0] entry_start(input logic [CODE_W-1:0] code);
    logic [SEC_W-1:0] h;
    logic [SEC_W-1:0] m;
    logic [SEC_W-1:0] s;
    h = SEC_W'(code[24:20]);
    m = SEC_W'(code[19:14]);
    s = SEC_W'(code[13:8]);
    return h * 17'd3600 + m * 17'd60 + s;
  endfunction

  // weekday enables with day d at bit 7-d, bit 7 always clear
  function automatic logic [7:0] day_bits(input logic [CODE_W-1:0] code);
    return {1'b0, code[31:25]};
  endfunction

endpackage

`default_nettype wire

>>> design/wst_cell.sv
// one schedule table entry with its share of the write, check and next-start work
// depends on wst_pkg
`default_nettype none

module wst_cell (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      en,
  input  wire [wst_pkg::CELL_ID_W-1:0] cell_id,
  input  wst_pkg::chain_t          req_in,
  output wst_pkg::chain_t          req_out
);
  import wst_pkg::*;

  logic [CODE_W-1:0] code;
  logic [LEN_W-1:0]  len;
  logic [SEC_W-1:0]  start;

  chain_t           req_next;
  logic             match;
  logic [7:0]       days;
  logic [SEC_W:0]   end_raw;
  logic [SEC_W:0]   end_cap;
  logic             active;
  logic             scan_on;
  logic             f0;
  logic             f1;
  logic [DAY_W-1:0] d0;
  logic [DAY_W-1:0] d1;
  logic [3:0]       off0;
  logic [3:0]       off1;
  logic [CAND_W-1:0] base0;
  logic [CAND_W-1:0] base1;
  logic [CAND_W-1:0] cand0;
  logic [CAND_W-1:0] cand1;

  assign match = (IDX_CMP_W'(req_in.idx) == IDX_CMP_W'(cell_id));
  assign days  = day_bits(code);

  // active window for the check request
  always_comb begin
    end_raw = {1'b0, start} + {1'b0, len};
    end_cap = (end_raw > DAY_SECONDS) ? DAY_SECONDS : end_raw;
    active  = days[3'd7 - req_in.today] && (start <= req_in.now) &&
              ({1'b0, req_in.now} <= end_cap);
  end

  // first enabled day in each pass, smallest day wins
  always_comb begin
    scan_on = (req_in.today != '0) && (len != '0);
    f0 = 1'b0;
    f1 = 1'b0;
    d0 = '0;
    d1 = '0;
    for (int d = 7; d >= 1; d--) begin
      if (days[3'(7 - d)] && (DAY_W'(d) >= req_in.today) &&
          ((DAY_W'(d) != req_in.today) || (start >= req_in.now))) begin
        f0 = 1'b1;
        d0 = DAY_W'(d);
      end
      if (days[3'(7 - d)] && (DAY_W'(d) <= req_in.today) &&
          ((DAY_W'(d) != req_in.today) || (start <= req_in.now))) begin
        f1 = 1'b1;
        d1 = DAY_W'(d);
      end
    end
    f0 = f0 && scan_on;
    f1 = f1 && scan_on;
  end

  // candidate distances, negative ones clamp to zero
  always_comb begin
    off0  = 4'({1'b0, d0} - {1'b0, req_in.today});
    off1  = 4'(4'd7 - {1'b0, req_in.today} + {1'b0, d1});
    base0 = CAND_W'(off0) * CAND_W'(DAY_SECONDS) + CAND_W'(start);
    base1 = CAND_W'(off1) * CAND_W'(DAY_SECONDS) + CAND_W'(start);
    cand0 = (base0 >= CAND_W'(req_in.now)) ? base0 - CAND_W'(req_in.now) : '0;
    cand1 = (base1 >= CAND_W'(req_in.now)) ? base1 - CAND_W'(req_in.now) : '0;
  end

  // fold this entry into the running results
  always_comb begin
    req_next = req_in;
    if (req_in.op == OP_CHECK && match && active) begin
      req_next.action = code[ACT_W-1:0];
    end
    if (req_in.op == OP_NEXT) begin
      if (f0) begin
        req_next.hit0 = 1'b1;
        if (cand0 < CAND_W'(req_in.min0)) begin
          req_next.min0 = cand0[NEXT_W-1:0];
        end
      end
      if (f1) begin
        req_next.hit1 = 1'b1;
        if (cand1 < CAND_W'(req_in.min1)) begin
          req_next.min1 = cand1[NEXT_W-1:0];
        end
      end
    end
  end

  // entry storage and hand-off register
  always_ff @(posedge clk) begin
    if (rst) begin
      code          <= '0;
      len           <= '0;
      start         <= '0;
      req_out.valid <= 1'b0;
    end else if (en) begin
      req_out <= req_next;
      if (req_in.valid && req_in.op == OP_WRITE && match) begin
        code  <= req_in.code;
        len   <= req_in.len;
        start <= entry_start(req_in.code);
      end
    end
  end

endmodule

`default_nettype wire

>>> design/weekly_schedule_table_top.sv
// top level of the weekly schedule table: stream ports, cell row, result register
// depends on wst_pkg and wst_cell
`default_nettype none

// Weekly schedule table. Every request (write entry, check entry, seconds to
// next start) runs down a row of TASK_COUNT cells, one per table entry, one
// cell per cycle, and yields one result. The cell row, whose first cell
// registers at the accepting edge and whose last cell feeds the output
// register, holds one request at a time; the next is taken as soon as the
// previous result sits in the output register, even if the sink has not taken
// it yet. A result that the sink holds back holds the row. The table clears to
// zero at reset.
module weekly_schedule_table_top (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // entry_index[3:0], start_code[35:4], run_length[52:36],
  // now_seconds[69:53], weekday[72:70], zero fill
  input  wire  [79:0] s_tdata,
  // opcode[1:0]
  input  wire  [1:0]  s_tuser,
  output logic        m_tvalid,
  input  wire         m_tready,
  // action_code[7:0], seconds_to_next[27:8], zero fill
  output logic [31:0] m_tdata,
  // found[0]
  output logic [0:0]  m_tuser
);
  import wst_pkg::*;

  chain_t chain [TASK_COUNT+1];
  chain_t head;
  chain_t tail;
  logic   inflight;
  logic   accept;
  logic   out_free;
  logic   adv;

  assign s_tready = !inflight;
  assign accept   = s_tvalid && s_tready;
  assign tail     = chain[TASK_COUNT];
  assign out_free = !m_tvalid || m_tready;
  assign adv      = out_free || !tail.valid;

  // request entering the first cell
  always_comb begin
    head.valid  = accept;
    head.op     = s_tuser;
    head.idx    = s_tdata[3:0];
    head.code   = s_tdata[35:4];
    head.len    = s_tdata[52:36];
    head.now    = s_tdata[69:53];
    head.today  = s_tdata[72:70];
    head.action = '0;
    head.hit0   = 1'b0;
    head.min0   = NONE_FOUND;
    head.hit1   = 1'b0;
    head.min1   = NONE_FOUND;
  end

  assign chain[0] = head;

  // row of entry cells
  for (genvar i = 0; i < TASK_COUNT; i++) begin : g_cell
    wst_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .cell_id (CELL_ID_W'(i)),
      .req_in  (chain[i]),
      .req_out (chain[i+1])
    );
  end

  // request tracking and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        inflight <= 1'b1;
      end else if (tail.valid && out_free) begin
        inflight <= 1'b0;
      end
      if (tail.valid && out_free) begin
        m_tvalid       <= 1'b1;
        m_tdata[7:0]   <= tail.action;
        m_tdata[27:8]  <= (tail.op == OP_NEXT) ? (tail.hit0 ? tail.min0 : tail.min1) : '0;
        m_tdata[31:28] <= '0;
        m_tuser[0]     <= (tail.op == OP_NEXT) && (tail.hit0 || tail.hit1);
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  // a result leaves the row only for a request that is being tracked
  a_tail_tracked: assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> inflight)
    else $error("result in cell row with no request outstanding");

  // accepting a request marks it outstanding
  a_accept_tracked: assert property (@(posedge clk) disable iff (rst)
    accept |=> inflight)
    else $error("accepted request not tracked");

  // a found flag only comes with a zero action code
  a_found_no_action: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[7:0] == 8'd0))
    else $error("found flag with nonzero action code");

  // without a found flag the distance is zero or the none value
  a_not_found_dist: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |->
      ((m_tdata[27:8] == 20'd0) || (m_tdata[27:8] == NONE_FOUND)))
    else $error("distance given without found flag");
`endif

endmodule

`default_nettype wire

>>> test/weekly_schedule_table_top_tb.sv
// testbench for weekly_schedule_table_top: directed and random requests against
// a built-in schedule predictor, with bursty sender and stalling receiver
// depends on wst_pkg and the weekly_schedule_table_top design files
module weekly_schedule_table_top_tb;
  import wst_pkg::*;

  // opcode that the block leaves unused
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         QUIET_LIMIT = 2000;
  localparam int         DRAIN_WAIT  = 60;

  typedef struct {
    logic [ACT_W-1:0]  action;
    logic [NEXT_W-1:0] wait_s;
    logic              found;
  } schedule_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [0:0]  m_tuser;

  // predictor copy of the task table
  logic [CODE_W-1:0] plan_code [TASK_COUNT];
  logic [LEN_W-1:0]  plan_len  [TASK_COUNT];

  schedule_reply_t replies_due[$];
  int errors = 0;
  int burst_left = 0;
  int stall_left = 0;
  int rx_mode = 0;
  int rx_phase = 0;
  int quiet = 0;

  weekly_schedule_table_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #1 clk = ~clk;

  // seconds after midnight of a start code, fields unchecked
  function automatic int start_secs(input logic [CODE_W-1:0] code);
    return int'(code[24:20]) * 3600 + int'(code[19:14]) * 60 + int'(code[13:8]);
  endfunction

  // monday is bit 31, sunday bit 25; other day numbers match nothing
  function automatic bit day_on(input logic [CODE_W-1:0] code, input int day);
    if (day < 1 || day > 7) return 1'b0;
    return code[5'(32 - day)];
  endfunction

  function automatic logic [CODE_W-1:0] make_code(input logic [6:0] days, input logic [4:0] hh,
                                                  input logic [5:0] mm, input logic [5:0] ss,
                                                  input logic [7:0] act);
    return {days, hh, mm, ss, act};
  endfunction

  // expected reply of one request, updating the table copy on writes
  function automatic schedule_reply_t predict_reply(input logic [1:0] op,
      input logic [IDX_W-1:0] idx, input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len,
      input logic [SEC_W-1:0] now, input logic [DAY_W-1:0] day);
    schedule_reply_t r;
    longint best;
    longint offset;
    longint cand;
    longint lim;
    bit hit;
    int pass;
    int d;
    int d_first;
    int d_last;
    int i;
    int st;
    r.action = '0;
    r.wait_s = '0;
    r.found  = 1'b0;
    case (op)
      OP_WRITE: begin
        if (int'(idx) < TASK_COUNT) begin
          plan_code[idx] = code;
          plan_len[idx]  = len;
        end
      end
      OP_CHECK: begin
        if (int'(idx) < TASK_COUNT) begin
          st  = start_secs(plan_code[idx]);
          lim = longint'(st) + longint'(plan_len[idx]);
          if (lim > 86400) lim = 86400;
          if (day_on(plan_code[idx], int'(day)) && st <= int'(now) && longint'(now) <= lim)
            r.action = plan_code[idx][7:0];
        end
      end
      OP_NEXT: begin
        best = longint'(NONE_FOUND);
        hit = 1'b0;
        offset = 0;
        if (day >= 1) begin
          for (pass = 0; pass < 2 && !hit; pass++) begin
            d_first = (pass == 0) ? int'(day) : 1;
            d_last  = (pass == 0) ? 7 : int'(day);
            for (d = d_first; d <= d_last; d++) begin
              for (i = 0; i < TASK_COUNT; i++) begin
                st = start_secs(plan_code[CELL_ID_W'(i)]);
                if (day_on(plan_code[CELL_ID_W'(i)], d) && plan_len[CELL_ID_W'(i)] != 0 &&
                    !(d == int'(day) && pass == 0 && st < int'(now)) &&
                    !(d == int'(day) && pass == 1 && st > int'(now))) begin
                  cand = offset * 86400 + longint'(st) - longint'(now);
                  if (cand < 0) cand = 0;
                  hit = 1'b1;
                  if (cand < best) best = cand;
                end
              end
              offset++;
            end
          end
        end
        r.wait_s = best[NEXT_W-1:0];
        r.found  = hit;
      end
      default: ;
    endcase
    return r;
  endfunction

  // send one request, idling between bursts of random length
  task automatic send_request(input logic [1:0] op, input logic [3:0] idx,
                              input logic [31:0] code, input logic [16:0] len,
                              input logic [16:0] now, input logic [2:0] day);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'd0, day, now, len, code, idx};
    do @(posedge clk); while (!s_tready);
    replies_due.push_back(predict_reply(op, idx, code, len, now, day));
  endtask

  // table must read as all zeros after reset
  task automatic test_cleared_table();
    send_request(OP_CHECK, 4'd0, '0, '0, 17'd0, 3'd1);
    send_request(OP_CHECK, 4'd15, '0, '0, 17'd0, 3'd7);
    send_request(OP_NEXT, 4'd0, '0, '0, 17'd0, 3'd3);
  endtask

  task automatic test_directed_cases();
    // every field at its top, start past midnight
    send_request(OP_WRITE, 4'd0, 32'hFFFF_FFFF, 17'h1FFFF, 17'd0, 3'd1);
    send_request(OP_CHECK, 4'd0, '0, '0, 17'd86400, 3'd7);
    // monday 08:00:00, ten minutes: both window edges and just past
    send_request(OP_WRITE, 4'd1, make_code(7'b1000000, 5'd8, 6'd0, 6'd0, 8'hA5), 17'd600,
                 17'd0, 3'd1);
    send_request(OP_CHECK, 4'd1, '0, '0, 17'd28800, 3'd1);
    send_request(OP_CHECK, 4'd1, '0, '0, 17'd29400, 3'd1);
    send_request(OP_CHECK, 4'd1, '0, '0, 17'd29401, 3'd1);
    send_request(OP_CHECK, 4'd1, '0, '0, 17'd28900, 3'd2);
    send_request(OP_CHECK, 4'd1, '0, '0, 17'd28900, 3'd0);
    // sunday 23:59:00 for an hour: end clipped at midnight
    send_request(OP_WRITE, 4'd15, make_code(7'b0000001, 5'd23, 6'd59, 6'd0, 8'h3C), 17'd3600,
                 17'd0, 3'd7);
    send_request(OP_CHECK, 4'd15, '0, '0, 17'd86400, 3'd7);
    send_request(OP_CHECK, 4'd15, '0, '0, 17'd86401, 3'd7);
    // start exactly now, then one second late
    send_request(OP_NEXT, 4'd0, '0, '0, 17'd28800, 3'd1);
    send_request(OP_NEXT, 4'd0, '0, '0, 17'd28801, 3'd1);
    // zero duration is skipped; late sunday wraps round to monday
    send_request(OP_WRITE, 4'd0, 32'hFFFF_FFFF, 17'd0, 17'd0, 3'd1);
    send_request(OP_NEXT, 4'd0, '0, '0, 17'd86399, 3'd7);
    // weekday zero finds nothing
    send_request(OP_NEXT, 4'd0, '0, '0, 17'd100, 3'd0);
    send_request(OP_CHECK, 4'd15, '0, '0, 17'd86400, 3'd0);
    // now beyond a day gives a negative candidate, held at zero
    send_request(OP_WRITE, 4'd2, make_code(7'b0000001, 5'd0, 6'd0, 6'd0, 8'h11), 17'd10,
                 17'd0, 3'd6);
    send_request(OP_NEXT, 4'd0, '0, '0, 17'h1FFFF, 3'd6);
    // unused opcode leaves the table alone
    send_request(OP_UNUSED, 4'd1, 32'hFFFF_FFFF, 17'h1FFFF, 17'd28800, 3'd1);
    send_request(OP_UNUSED, 4'd15, '0, '0, 17'd0, 3'd0);
    send_request(OP_CHECK, 4'd1, '0, '0, 17'd28800, 3'd1);
    send_request(OP_NEXT, 4'd0, '0, '0, 17'd0, 3'd7);
  endtask

  // well-formed schedules with checks aimed at live windows
  task automatic test_weekly_plans(input int count);
    int n;
    int pick;
    int k;
    int t;
    logic [3:0]  idx;
    logic [2:0]  day;
    logic [16:0] now;
    logic [16:0] len;
    logic [31:0] code;
    for (n = 0; n < count; n++) begin
      idx  = 4'($urandom_range(15));
      pick = $urandom_range(99);
      if (pick < 30) begin
        if (pick < 3)
          code = make_code(7'($urandom_range(127)), 5'($urandom_range(31)),
                           6'($urandom_range(63)), 6'($urandom_range(63)),
                           8'($urandom_range(255)));
        else
          code = make_code(7'($urandom_range(127)), 5'($urandom_range(23)),
                           6'($urandom_range(59)), 6'($urandom_range(59)),
                           8'($urandom_range(255)));
        case ($urandom_range(9))
          0:       len = '0;
          1:       len = 17'($urandom_range(131071));
          default: len = 17'($urandom_range(1, 7200));
        endcase
        send_request(OP_WRITE, idx, code, len, 17'($urandom_range(86399)),
                     3'($urandom_range(1, 7)));
      end else if (pick < 65) begin
        if ($urandom_range(2) != 0) begin
          t = start_secs(plan_code[idx]) + int'($urandom_range(plan_len[idx]))
              + int'($urandom_range(2)) - 1;
          if (t < 0) t = 0;
          if (t > 131071) t = 131071;
          now = 17'(t);
        end else begin
          now = 17'($urandom_range(86399));
        end
        day = 3'($urandom_range(1, 7));
        if ($urandom_range(9) < 7)
          for (k = 0; k < 8 && !day_on(plan_code[idx], int'(day)); k++)
            day = 3'($urandom_range(1, 7));
        send_request(OP_CHECK, idx, $urandom, 17'($urandom_range(131071)), now, day);
      end else begin
        if ($urandom_range(3) == 0)
          now = 17'(start_secs(plan_code[4'($urandom_range(15))]));
        else
          now = 17'($urandom_range(86399));
        send_request(OP_NEXT, idx, $urandom, 17'($urandom_range(131071)), now,
                     3'($urandom_range(1, 7)));
      end
    end
  endtask

  // unconstrained fields, all opcodes and day numbers
  task automatic test_raw_requests(input int count);
    int n;
    for (n = 0; n < count; n++)
      send_request(2'($urandom_range(3)), 4'($urandom_range(15)), $urandom,
                   17'($urandom_range(131071)), 17'($urandom_range(131071)),
                   3'($urandom_range(7)));
  endtask

  // receiver stalls, switching between no, short and long stalls
  always @(posedge clk) begin
    rx_phase <= (rx_phase == 199) ? 0 : rx_phase + 1;
    if (rx_phase == 199) rx_mode <= $urandom_range(2);
    if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if (rx_mode == 1 && $urandom_range(99) < 40) stall_left <= $urandom_range(1, 3);
      if (rx_mode == 2 && $urandom_range(99) < 5) stall_left <= $urandom_range(5, 40);
    end
  end

  // compare each reply with the oldest expectation
  always @(posedge clk) begin : check_replies
    schedule_reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (replies_due.size() == 0) begin
        $error("reply with no request pending: m_tdata=%h m_tuser=%b", m_tdata, m_tuser);
        errors++;
      end else begin
        want = replies_due.pop_front();
        if (m_tdata[7:0] !== want.action) begin
          $error("action_code: expected %0d, got %0d", want.action, m_tdata[7:0]);
          errors++;
        end
        if (m_tdata[27:8] !== want.wait_s) begin
          $error("seconds_to_next: expected %0d, got %0d", want.wait_s, m_tdata[27:8]);
          errors++;
        end
        if (m_tuser[0] !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, m_tuser[0]);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    // table copy starts cleared, as the block does after reset
    foreach (plan_code[i]) begin
      plan_code[i] = '0;
      plan_len[i]  = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_cleared_table();
    test_directed_cases();
    test_weekly_plans(720);
    test_raw_requests(300);
    s_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
